// ----- rtl/tct_pkg.sv -----
// Shared types and constants for the touch contact tracking table.
package tct_pkg;

  localparam int DEPTH  = 16;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CFG_W  = 5;
  localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int ID_W   = 32;
  localparam int FLAG_W = 16;
  localparam int MODE_W = 3;
  localparam int OSLOT_W = 4;
  localparam int OCNT_W  = 5;

  typedef enum logic [MODE_W-1:0] {
    MODE_START   = 3'd0,
    MODE_MSTART  = 3'd1,
    MODE_MOVE    = 3'd2,
    MODE_END     = 3'd3,
    MODE_CANCEL  = 3'd4,
    MODE_CLR_ALL = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_START,
    OP_MOVE,
    OP_FREE,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t             op;
    logic [ID_W-1:0] id;
  } cmd_t;

  typedef struct packed {
    logic               listened;
    logic [OSLOT_W-1:0] slot;
    logic [OCNT_W-1:0]  active_count;
    logic [OCNT_W-1:0]  cleared_count;
  } res_t;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } st_t;

endpackage

// ----- rtl/tct_front.sv -----
// Front end: accepts events, classifies them and queues commands for the table engine.
module tct_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [tct_pkg::MODE_W-1:0]  in_mode,
  input  logic [tct_pkg::ID_W-1:0]    in_touch_id,
  input  logic [tct_pkg::FLAG_W-1:0]  in_touch_flags,
  input  logic [tct_pkg::FLAG_W-1:0]  in_lock_mask,
  output logic                        cmd_valid,
  output tct_pkg::cmd_t               cmd,
  input  logic                        cmd_pop
);

  tct_pkg::cmd_t fq_r [2];
  logic          wp_r, wp_nxt;
  logic          rp_r, rp_nxt;
  logic [1:0]    cnt_r, cnt_nxt;
  logic          push;
  logic          pop;
  tct_pkg::cmd_t new_cmd;

  always_comb begin
    new_cmd.id = in_touch_id;
    unique case (in_mode)
      tct_pkg::MODE_START: begin
        new_cmd.op = tct_pkg::OP_START;
      end
      tct_pkg::MODE_MSTART: begin
        // refused when the flags carry every lock bit
        new_cmd.op = ((in_touch_flags & in_lock_mask) == in_lock_mask) ?
                     tct_pkg::OP_NOP : tct_pkg::OP_START;
      end
      tct_pkg::MODE_MOVE: begin
        new_cmd.op = tct_pkg::OP_MOVE;
      end
      tct_pkg::MODE_END, tct_pkg::MODE_CANCEL: begin
        new_cmd.op = tct_pkg::OP_FREE;
      end
      tct_pkg::MODE_CLR_ALL: begin
        new_cmd.op = tct_pkg::OP_CLEAR;
      end
      default: begin
        new_cmd.op = tct_pkg::OP_NOP;
      end
    endcase
  end

  assign in_full   = (cnt_r == 2'd2);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd       = fq_r[rp_r];
  assign push      = in_push && !in_full;
  assign pop       = cmd_pop && cmd_valid;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fq_r[wp_r] <= new_cmd;
    end
  end

endmodule

// ----- rtl/tct_back.sv -----
// Back end: table storage, sequential slot scan, write-back and result queue.
module tct_back (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cmd_valid,
  input  tct_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  input  logic                       cfg_we,
  input  logic [tct_pkg::CFG_W-1:0]  cfg_data,
  output logic                       res_valid,
  output tct_pkg::res_t              res,
  input  logic                       res_pop
);

  localparam logic [tct_pkg::SLOT_W-1:0] LAST_IDX = tct_pkg::SLOT_W'(tct_pkg::DEPTH - 1);
  localparam logic [tct_pkg::CMP_W-1:0]  DEPTH_C  = tct_pkg::CMP_W'(tct_pkg::DEPTH);

  logic [tct_pkg::DEPTH-1:0]   valid_r;
  logic [tct_pkg::ID_W-1:0]    id_r [tct_pkg::DEPTH];
  logic [tct_pkg::CFG_W-1:0]   lim_r;
  logic [tct_pkg::CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [tct_pkg::SLOT_W-1:0]  idx_r, idx_nxt;
  tct_pkg::st_t                st_r, st_nxt;
  tct_pkg::op_t                op_r;
  logic [tct_pkg::ID_W-1:0]    cid_r;

  logic                        latch;
  logic                        wr_en;
  logic                        wr_val;
  logic                        clr_all;
  logic                        hit;
  logic                        push;
  tct_pkg::res_t               new_res;
  logic [tct_pkg::CMP_W-1:0]   eff_lim;

  tct_pkg::res_t               oq_r [2];
  logic                        owp_r, orp_r;
  logic [1:0]                  ocnt_r;
  logic                        opop;

  assign eff_lim = (tct_pkg::CMP_W'(lim_r) > DEPTH_C) ? DEPTH_C : tct_pkg::CMP_W'(lim_r);
  assign hit = (op_r == tct_pkg::OP_START) ? !valid_r[idx_r] :
               (valid_r[idx_r] && (id_r[idx_r] == cid_r));

  always_comb begin
    st_nxt  = st_r;
    idx_nxt = idx_r;
    cnt_nxt = cnt_r;
    cmd_pop = 1'b0;
    latch   = 1'b0;
    wr_en   = 1'b0;
    wr_val  = 1'b0;
    clr_all = 1'b0;
    push    = 1'b0;
    new_res = '0;
    unique case (st_r)
      tct_pkg::ST_IDLE: begin
        if (cmd_valid && (ocnt_r != 2'd2)) begin
          cmd_pop = 1'b1;
          latch   = 1'b1;
          idx_nxt = '0;
          case (cmd.op)
            tct_pkg::OP_START: begin
              if (tct_pkg::CMP_W'(cnt_r) >= eff_lim) begin
                push = 1'b1;
              end else begin
                st_nxt = tct_pkg::ST_SCAN;
              end
            end
            tct_pkg::OP_MOVE, tct_pkg::OP_FREE: begin
              st_nxt = tct_pkg::ST_SCAN;
            end
            tct_pkg::OP_CLEAR: begin
              clr_all = 1'b1;
              cnt_nxt = '0;
              push    = 1'b1;
              new_res.cleared_count = tct_pkg::OCNT_W'(cnt_r);
            end
            default: begin
              push = 1'b1;
            end
          endcase
        end
      end
      tct_pkg::ST_SCAN: begin
        if (hit) begin
          push   = 1'b1;
          st_nxt = tct_pkg::ST_IDLE;
          new_res.listened = 1'b1;
          new_res.slot     = tct_pkg::OSLOT_W'(idx_r);
          case (op_r)
            tct_pkg::OP_START: begin
              wr_en   = 1'b1;
              wr_val  = 1'b1;
              cnt_nxt = cnt_r + 1'b1;
            end
            tct_pkg::OP_FREE: begin
              wr_en = 1'b1;
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end else if (idx_r == LAST_IDX) begin
          push   = 1'b1;
          st_nxt = tct_pkg::ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        st_nxt = tct_pkg::ST_IDLE;
      end
    endcase
    new_res.active_count = tct_pkg::OCNT_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= tct_pkg::ST_IDLE;
      idx_r   <= '0;
      cnt_r   <= '0;
      valid_r <= '0;
      lim_r   <= tct_pkg::CFG_W'(16);
    end else begin
      st_r  <= st_nxt;
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
      if (cfg_we) begin
        lim_r <= cfg_data;
      end
      if (clr_all) begin
        valid_r <= '0;
      end else if (wr_en) begin
        valid_r[idx_r] <= wr_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (latch) begin
      op_r  <= cmd.op;
      cid_r <= cmd.id;
    end
    if (wr_en && wr_val) begin
      id_r[idx_r] <= cid_r;
    end
  end

  // result queue, two beats
  assign res_valid = (ocnt_r != 2'd0);
  assign res       = oq_r[orp_r];
  assign opop      = res_pop && res_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      owp_r  <= 1'b0;
      orp_r  <= 1'b0;
      ocnt_r <= 2'd0;
    end else begin
      if (push) begin
        owp_r <= ~owp_r;
      end
      if (opop) begin
        orp_r <= ~orp_r;
      end
      if (push && !opop) begin
        ocnt_r <= ocnt_r + 2'd1;
      end else if (opop && !push) begin
        ocnt_r <= ocnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq_r[owp_r] <= new_res;
    end
  end

endmodule

// ----- rtl/touch_contact_tracking_table.sv -----
// Top level of the touch contact tracking table.
// Tracks up to sixteen touch contacts by 32-bit id, limited by max_listened
// (reset 16). Events enter a two-beat command queue and results leave through
// a two-beat result queue, so both sides may stall independently. The table
// engine handles one event at a time: start, move, end and cancel scan the
// slots one per cycle, up to and including the hit slot (the hit position plus
// one slots, all sixteen slots on a miss); cancel all, refused starts and
// unused modes finish without a scan. max_listened may be written only while
// the block is idle; cfg_ready is always high.
module touch_contact_tracking_table (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [tct_pkg::MODE_W-1:0]  in_mode,
  input  logic [tct_pkg::ID_W-1:0]    in_touch_id,
  input  logic [tct_pkg::FLAG_W-1:0]  in_touch_flags,
  input  logic [tct_pkg::FLAG_W-1:0]  in_lock_mask,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_listened,
  output logic [tct_pkg::OSLOT_W-1:0] out_slot,
  output logic [tct_pkg::OCNT_W-1:0]  out_active_count,
  output logic [tct_pkg::OCNT_W-1:0]  out_cleared_count,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [tct_pkg::CFG_W-1:0]   cfg_max_listened
);

  logic          cmd_valid;
  logic          cmd_pop;
  tct_pkg::cmd_t cmd;
  logic          res_valid;
  tct_pkg::res_t res;

  assign cfg_ready = 1'b1;

  tct_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_push        (in_push),
    .in_full        (in_full),
    .in_mode        (in_mode),
    .in_touch_id    (in_touch_id),
    .in_touch_flags (in_touch_flags),
    .in_lock_mask   (in_lock_mask),
    .cmd_valid      (cmd_valid),
    .cmd            (cmd),
    .cmd_pop        (cmd_pop)
  );

  tct_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_max_listened),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (out_pop)
  );

  assign out_empty         = !res_valid;
  assign out_listened      = res.listened;
  assign out_slot          = res.slot;
  assign out_active_count  = res.active_count;
  assign out_cleared_count = res.cleared_count;

endmodule
